### hw/rtl/assert_macros.svh
// assertion helpers included by the compensation top
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked at every edge outside reset
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// implication checked in the cycle after the antecedent
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/thp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thp_pkg
// Types, constants and arithmetic helpers of the sensor compensation block.
// ----------------------------------------------------------------------------
package thp_pkg;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 64;
  localparam int DIV_STEPS = 64;

  localparam logic [CFG_IDX_W-1:0] CFG_TEMP      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PRESS_LO  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PRESS_HI  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PRESS_HUM = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_HUM       = 3'd4;

  localparam logic [31:0] HUM_LIMIT = 32'd419430400;

  typedef struct packed {
    logic [19:0] raw_temperature;
    logic [19:0] raw_pressure;
    logic [15:0] raw_humidity;
  } in_t;

  typedef struct packed {
    logic signed [31:0] temperature_centi;
    logic [31:0]        pressure_pa;
    logic [16:0]        humidity_q10;
  } out_t;

  typedef struct packed {
    logic [31:0] t1, t2, t3;
    logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic [31:0] h1, h2, h3, h4, h5, h6;
  } calib_t;

  // partial products of a wrapping 64x64 multiply
  typedef struct packed {
    logic [63:0] ll;
    logic [31:0] cr;
  } mp_t;

  typedef struct packed {
    logic [63:0] rem;
    logic [63:0] nq;
    logic [63:0] den;
  } div_t;

  typedef struct packed {
    logic        neg;
    logic        zero;
    logic [31:0] tc;
    logic [16:0] hum;
  } side_t;

  function automatic logic [31:0] asr32(input logic [31:0] x, input int n);
    logic signed [31:0] s;
    s = x;
    return s >>> n;
  endfunction

  function automatic logic [63:0] asr64(input logic [63:0] x, input int n);
    logic signed [63:0] s;
    s = x;
    return s >>> n;
  endfunction

  function automatic mp_t mul64_p(input logic [63:0] a, input logic [63:0] b);
    mp_t r;
    r.ll = {32'd0, a[31:0]} * {32'd0, b[31:0]};
    r.cr = a[63:32] * b[31:0] + a[31:0] * b[63:32];
    return r;
  endfunction

  function automatic logic [63:0] mul64_s(input mp_t p);
    return p.ll + {p.cr, 32'd0};
  endfunction

  function automatic logic [63:0] sx64(input logic [15:0] v);
    return {{48{v[15]}}, v};
  endfunction

  function automatic calib_t unpack_calib(input logic [47:0] tcal, input logic [63:0] plo,
                                          input logic [63:0] phi, input logic [47:0] phc,
                                          input logic [39:0] hcal);
    calib_t c;
    c.t1 = {16'd0, tcal[15:0]};
    c.t2 = {{16{tcal[31]}}, tcal[31:16]};
    c.t3 = {{16{tcal[47]}}, tcal[47:32]};
    c.p1 = {48'd0, plo[15:0]};
    c.p2 = sx64(plo[31:16]);
    c.p3 = sx64(plo[47:32]);
    c.p4 = sx64(plo[63:48]);
    c.p5 = sx64(phi[15:0]);
    c.p6 = sx64(phi[31:16]);
    c.p7 = sx64(phi[47:32]);
    c.p8 = sx64(phi[63:48]);
    c.p9 = sx64(phc[15:0]);
    c.h1 = {24'd0, phc[23:16]};
    c.h2 = {{16{phc[39]}}, phc[39:24]};
    c.h3 = {24'd0, phc[47:40]};
    c.h4 = {{16{hcal[15]}}, hcal[15:0]};
    c.h5 = {{16{hcal[31]}}, hcal[31:16]};
    c.h6 = {{24{hcal[39]}}, hcal[39:32]};
    return c;
  endfunction

endpackage

### hw/rtl/thp_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thp_front
// Fifteen stage pipeline: temperature, humidity and the pressure dividend and
// divisor, handed on as magnitudes for the divider.
// ----------------------------------------------------------------------------
module thp_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            in_valid,
  input  thp_pkg::in_t    in_data,
  input  thp_pkg::calib_t cal,
  output logic            out_valid,
  output thp_pkg::div_t   out_div,
  output thp_pkg::side_t  out_side
);

  logic [15:1] v_r;

  logic [31:0] a1_1_r, d_1_r, m1_2_r, dd_2_r, v1_3_r, q_3_r, tf_4_r;
  logic [31:0] tc_r [5:15];
  logic [19:0] ap_r [1:10];
  logic [15:0] ah_r [1:6];
  logic [63:0] w1_5_r;
  logic [31:0] x_5_r;
  logic [31:0] hm5x_6_r, mx6_6_r, mx3_6_r;
  thp_pkg::mp_t pww_6_r, pw5_6_r, pw2_6_r;
  logic [31:0] ha_r [7:11];
  logic [31:0] hb1_7_r, hb2_7_r;
  logic [63:0] ww_7_r;
  logic [63:0] w1p5_r [7:9];
  logic [63:0] w1p2_r [7:9];
  logic [31:0] hb_8_r, hb_9_r, hbm_10_r, hb_11_r;
  thp_pkg::mp_t pw6_8_r, pw3_8_r;
  logic [63:0] ww6_9_r, ww3_9_r, w2_10_r, w1b_10_r;
  thp_pkg::mp_t pp1_11_r, pnm_12_r;
  logic [63:0] pn_11_r, prod1_12_r;
  logic [31:0] hx_12_r, hx_13_r, hx_14_r, s2_13_r, hq_14_r;
  logic [63:0] den_13_r, num_13_r, den_14_r, num_14_r;
  thp_pkg::div_t  div_15_r;
  thp_pkg::side_t side_15_r;

  logic [31:0] ha_nxt, s_nxt, hum_x_nxt;
  logic [63:0] w2_nxt, pn_nxt, pnb_nxt;
  thp_pkg::div_t  div_nxt;
  thp_pkg::side_t side_nxt;

  always_comb begin
    ha_nxt = thp_pkg::asr32(({16'd0, ah_r[6]} << 14) - {cal.h4[11:0], 20'd0}
                            - hm5x_6_r + 32'd16384, 15);
    w2_nxt = ww6_9_r + {w1p5_r[9][46:0], 17'd0} + {cal.p4[28:0], 35'd0};
    pnb_nxt = 64'd1048576 - {44'd0, ap_r[10]};
    pn_nxt = {pnb_nxt[32:0], 31'd0} - w2_10_r;
    s_nxt = thp_pkg::asr32(hx_12_r, 15);
    hum_x_nxt = hx_14_r - thp_pkg::asr32(hq_14_r, 4);
    side_nxt.tc = tc_r[14];
    side_nxt.zero = (den_14_r == 64'd0);
    side_nxt.neg = num_14_r[63] ^ den_14_r[63];
    if (hum_x_nxt[31]) begin
      side_nxt.hum = '0;
    end else if (hum_x_nxt > thp_pkg::HUM_LIMIT) begin
      side_nxt.hum = thp_pkg::HUM_LIMIT[28:12];
    end else begin
      side_nxt.hum = hum_x_nxt[28:12];
    end
    div_nxt.rem = '0;
    div_nxt.nq = num_14_r[63] ? 64'd0 - num_14_r : num_14_r;
    div_nxt.den = den_14_r[63] ? 64'd0 - den_14_r : den_14_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[14:1], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // temperature
      a1_1_r <= ({12'd0, in_data.raw_temperature} >> 3) - {cal.t1[30:0], 1'b0};
      d_1_r  <= ({12'd0, in_data.raw_temperature} >> 4) - cal.t1;
      ap_r[1] <= in_data.raw_pressure;
      ah_r[1] <= in_data.raw_humidity;
      for (int i = 2; i <= 10; i++) ap_r[i] <= ap_r[i-1];
      for (int i = 2; i <= 6; i++) ah_r[i] <= ah_r[i-1];
      m1_2_r <= a1_1_r * cal.t2;
      dd_2_r <= d_1_r * d_1_r;
      v1_3_r <= thp_pkg::asr32(m1_2_r, 11);
      q_3_r  <= thp_pkg::asr32(dd_2_r, 12) * cal.t3;
      tf_4_r <= v1_3_r + thp_pkg::asr32(q_3_r, 14);
      tc_r[5] <= thp_pkg::asr32(tf_4_r * 32'd5 + 32'd128, 8);
      for (int i = 6; i <= 15; i++) tc_r[i] <= tc_r[i-1];
      w1_5_r <= {{32{tf_4_r[31]}}, tf_4_r} - 64'd128000;
      x_5_r  <= tf_4_r - 32'd76800;
      // stage 6
      hm5x_6_r <= cal.h5 * x_5_r;
      mx6_6_r  <= x_5_r * cal.h6;
      mx3_6_r  <= x_5_r * cal.h3;
      pww_6_r  <= thp_pkg::mul64_p(w1_5_r, w1_5_r);
      pw5_6_r  <= thp_pkg::mul64_p(w1_5_r, cal.p5);
      pw2_6_r  <= thp_pkg::mul64_p(w1_5_r, cal.p2);
      // stage 7
      ha_r[7] <= ha_nxt;
      for (int i = 8; i <= 11; i++) ha_r[i] <= ha_r[i-1];
      hb1_7_r <= thp_pkg::asr32(mx6_6_r, 10);
      hb2_7_r <= thp_pkg::asr32(mx3_6_r, 11) + 32'd32768;
      ww_7_r  <= thp_pkg::mul64_s(pww_6_r);
      w1p5_r[7] <= thp_pkg::mul64_s(pw5_6_r);
      w1p2_r[7] <= thp_pkg::mul64_s(pw2_6_r);
      for (int i = 8; i <= 9; i++) begin
        w1p5_r[i] <= w1p5_r[i-1];
        w1p2_r[i] <= w1p2_r[i-1];
      end
      // stage 8
      hb_8_r  <= hb1_7_r * hb2_7_r;
      pw6_8_r <= thp_pkg::mul64_p(ww_7_r, cal.p6);
      pw3_8_r <= thp_pkg::mul64_p(ww_7_r, cal.p3);
      // stage 9
      hb_9_r  <= thp_pkg::asr32(hb_8_r, 10) + 32'd2097152;
      ww6_9_r <= thp_pkg::mul64_s(pw6_8_r);
      ww3_9_r <= thp_pkg::mul64_s(pw3_8_r);
      // stage 10
      hbm_10_r <= hb_9_r * cal.h2;
      w2_10_r  <= w2_nxt;
      w1b_10_r <= thp_pkg::asr64(ww3_9_r, 8) + {w1p2_r[9][51:0], 12'd0};
      // stage 11
      hb_11_r  <= thp_pkg::asr32(hbm_10_r + 32'd8192, 14);
      pp1_11_r <= thp_pkg::mul64_p(w1b_10_r + 64'h0000_8000_0000_0000, cal.p1);
      pn_11_r  <= pn_nxt;
      // stage 12
      hx_12_r    <= ha_r[11] * hb_11_r;
      prod1_12_r <= thp_pkg::mul64_s(pp1_11_r);
      pnm_12_r   <= thp_pkg::mul64_p(pn_11_r, 64'd3125);
      // stage 13
      s2_13_r  <= s_nxt * s_nxt;
      hx_13_r  <= hx_12_r;
      den_13_r <= thp_pkg::asr64(prod1_12_r, 33);
      num_13_r <= thp_pkg::mul64_s(pnm_12_r);
      // stage 14
      hq_14_r  <= thp_pkg::asr32(s2_13_r, 7) * cal.h1;
      hx_14_r  <= hx_13_r;
      den_14_r <= den_13_r;
      num_14_r <= num_13_r;
      // stage 15
      div_15_r  <= div_nxt;
      side_15_r <= side_nxt;
    end
  end

  assign out_valid = v_r[15];
  assign out_div   = div_15_r;
  assign out_side  = side_15_r;

endmodule

### hw/rtl/thp_div_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thp_div_stage
// One restoring step of the unsigned 64-bit divider, one quotient bit.
// ----------------------------------------------------------------------------
module thp_div_stage (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           in_valid,
  input  thp_pkg::div_t  in_div,
  input  thp_pkg::side_t in_side,
  output logic           out_valid,
  output thp_pkg::div_t  out_div,
  output thp_pkg::side_t out_side
);

  logic           valid_r;
  thp_pkg::div_t  div_r, div_nxt;
  thp_pkg::side_t side_r;
  logic [64:0]    trial;

  always_comb begin
    trial = {in_div.rem, in_div.nq[63]};
    div_nxt.den = in_div.den;
    if (trial >= {1'b0, in_div.den}) begin
      div_nxt.rem = 64'(trial - {1'b0, in_div.den});
      div_nxt.nq  = {in_div.nq[62:0], 1'b1};
    end else begin
      div_nxt.rem = trial[63:0];
      div_nxt.nq  = {in_div.nq[62:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      div_r  <= div_nxt;
      side_r <= in_side;
    end
  end

  assign out_valid = valid_r;
  assign out_div   = div_r;
  assign out_side  = side_r;

endmodule

### hw/rtl/thp_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thp_back
// Six stage pipeline: signs the quotient, applies the P7..P9 correction and
// holds the result register.
// ----------------------------------------------------------------------------
module thp_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            in_valid,
  input  logic [63:0]     in_quot,
  input  thp_pkg::side_t  in_side,
  input  thp_pkg::calib_t cal,
  output logic            out_valid,
  output thp_pkg::out_t   out_data
);

  logic [6:1] v_r;
  thp_pkg::side_t side_r [1:5];
  logic [63:0] p_r [1:5];
  logic [63:0] s13_2_r, s13_3_r, t1_3_r, t2_5_r;
  logic [63:0] e2p_r [3:5];
  thp_pkg::mp_t pa_2_r, pb_2_r, pc_4_r;
  thp_pkg::out_t out_r, out_nxt;
  logic [63:0] s13_nxt, sum_nxt, pr_nxt;

  always_comb begin
    s13_nxt = thp_pkg::asr64(p_r[1], 13);
    sum_nxt = p_r[5] + thp_pkg::asr64(t2_5_r, 25) + thp_pkg::asr64(e2p_r[5], 19);
    pr_nxt = thp_pkg::asr64(sum_nxt, 8) + {cal.p7[59:0], 4'd0};
    out_nxt.temperature_centi = side_r[5].tc;
    out_nxt.pressure_pa = side_r[5].zero ? 32'd0 : pr_nxt[31:0];
    out_nxt.humidity_q10 = side_r[5].hum;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[5:1], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[1] <= in_side;
      p_r[1]    <= in_side.neg ? 64'd0 - in_quot : in_quot;
      for (int i = 2; i <= 5; i++) begin
        side_r[i] <= side_r[i-1];
        p_r[i]    <= p_r[i-1];
      end
      s13_2_r <= s13_nxt;
      pa_2_r  <= thp_pkg::mul64_p(cal.p9, s13_nxt);
      pb_2_r  <= thp_pkg::mul64_p(cal.p8, p_r[1]);
      s13_3_r <= s13_2_r;
      t1_3_r  <= thp_pkg::mul64_s(pa_2_r);
      e2p_r[3] <= thp_pkg::mul64_s(pb_2_r);
      e2p_r[4] <= e2p_r[3];
      e2p_r[5] <= e2p_r[4];
      pc_4_r  <= thp_pkg::mul64_p(t1_3_r, s13_3_r);
      t2_5_r  <= thp_pkg::mul64_s(pc_4_r);
      out_r   <= out_nxt;
    end
  end

  assign out_valid = v_r[6];
  assign out_data  = out_r;

endmodule

### hw/rtl/thp_sensor_compensation_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thp_sensor_compensation_top
// Integer compensation of raw temperature, pressure and humidity conversions.
// ----------------------------------------------------------------------------
//  channel | ports                          | direction
//  input   | in_valid, in_stall, in_data    | raw triple in
//  result  | out_valid, out_stall, out_data | compensated triple out
//  config  | cfg_we, cfg_index, cfg_wdata   | calibration writes
//
//  one item per cycle while the pipe does not hold; 15 front stages, 64 divider steps
//  (one quotient bit each), 6 back stages including the result register.
//  rst_n synchronous; calibration registers reset to zero.
//  the whole pipe holds while the result register is full and stalled.
module thp_sensor_compensation_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  thp_pkg::in_t                        in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output thp_pkg::out_t                       out_data,
  input  logic                                cfg_we,
  input  logic [thp_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [thp_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  `include "assert_macros.svh"

  logic [47:0] temp_cal_r, press_hum_cal_r;
  logic [63:0] press_lo_r, press_hi_r;
  logic [39:0] hum_cal_r;
  thp_pkg::calib_t cal;
  logic en;

  logic           div_v [0:thp_pkg::DIV_STEPS];
  thp_pkg::div_t  div_d [0:thp_pkg::DIV_STEPS];
  thp_pkg::side_t div_s [0:thp_pkg::DIV_STEPS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      temp_cal_r      <= '0;
      press_lo_r      <= '0;
      press_hi_r      <= '0;
      press_hum_cal_r <= '0;
      hum_cal_r       <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        thp_pkg::CFG_TEMP:      temp_cal_r      <= cfg_wdata[47:0];
        thp_pkg::CFG_PRESS_LO:  press_lo_r      <= cfg_wdata;
        thp_pkg::CFG_PRESS_HI:  press_hi_r      <= cfg_wdata;
        thp_pkg::CFG_PRESS_HUM: press_hum_cal_r <= cfg_wdata[47:0];
        thp_pkg::CFG_HUM:       hum_cal_r       <= cfg_wdata[39:0];
        default: ;
      endcase
    end
  end

  assign cal = thp_pkg::unpack_calib(temp_cal_r, press_lo_r, press_hi_r,
                                     press_hum_cal_r, hum_cal_r);

  // every stage advances unless the result register is held
  assign en = !(out_valid && out_stall);
  assign in_stall = !en;

  thp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .cal       (cal),
    .out_valid (div_v[0]),
    .out_div   (div_d[0]),
    .out_side  (div_s[0])
  );

  for (genvar g = 0; g < thp_pkg::DIV_STEPS; g++) begin : g_div
    thp_div_stage u_step (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (en),
      .in_valid  (div_v[g]),
      .in_div    (div_d[g]),
      .in_side   (div_s[g]),
      .out_valid (div_v[g+1]),
      .out_div   (div_d[g+1]),
      .out_side  (div_s[g+1])
    );
  end

  thp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (div_v[thp_pkg::DIV_STEPS]),
    .in_quot   (div_d[thp_pkg::DIV_STEPS].nq),
    .in_side   (div_s[thp_pkg::DIV_STEPS]),
    .cal       (cal),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  `ASSERT_IMPL(a_hold_back, out_valid && out_stall, in_stall,
               "input taken while result register is held")
  `ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data),
               "stalled transfer changed")
  `ASSERT_IMPL(a_hum_range, out_valid, out_data.humidity_q10 <= 17'd102400,
               "humidity above clamp limit")

endmodule
